/* design/cmphd_pkg.sv */
`timescale 1ns / 1ps
package cmphd_pkg;

   // Command codes carried by the cmd field of an input item.
   localparam logic [1:0] CMD_SEED    = 2'd0;
   localparam logic [1:0] CMD_WIDEN   = 2'd1;
   localparam logic [1:0] CMD_OFFSETS = 2'd2;
   localparam logic [1:0] CMD_HEADING = 2'd3;

   typedef logic [1:0]         cmd_type;
   typedef logic signed [15:0] sample_type;
   typedef logic [8:0]         heading_type;

   // Differences after offset removal are one bit wider than a sample.
   localparam int DIFF_W = 17;
   // CORDIC datapath: difference scaled by 256 plus headroom for the gain.
   localparam int XY_W   = 28;
   // Angle accumulator in degrees with 16 fraction bits.
   localparam int ANG_W  = 28;
   localparam int FRAC_W = 16;
   localparam int TAB_IDX_W = 5;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [XY_W-1:0]   xy_type;
   typedef logic signed [ANG_W-1:0]  ang_type;

   localparam ang_type HALF_TURN_Q16 = ang_type'(180 * 65536);
   localparam ang_type FULL_TURN_Q16 = ang_type'(360 * 65536);

   // atan(2^-i) in degrees, 16 fraction bits, rounded.
   function automatic ang_type atan_q16(input logic [TAB_IDX_W-1:0] idx);
      ang_type val;
      case (idx)
         5'd0:  val = ang_type'(2949120);
         5'd1:  val = ang_type'(1740967);
         5'd2:  val = ang_type'(919879);
         5'd3:  val = ang_type'(466945);
         5'd4:  val = ang_type'(234379);
         5'd5:  val = ang_type'(117304);
         5'd6:  val = ang_type'(58666);
         5'd7:  val = ang_type'(29335);
         5'd8:  val = ang_type'(14668);
         5'd9:  val = ang_type'(7334);
         5'd10: val = ang_type'(3667);
         5'd11: val = ang_type'(1833);
         5'd12: val = ang_type'(917);
         5'd13: val = ang_type'(458);
         5'd14: val = ang_type'(229);
         5'd15: val = ang_type'(115);
         5'd16: val = ang_type'(57);
         5'd17: val = ang_type'(29);
         5'd18: val = ang_type'(14);
         5'd19: val = ang_type'(7);
         5'd20: val = ang_type'(4);
         5'd21: val = ang_type'(2);
         5'd22: val = ang_type'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* design/cmphd_if.sv */
`timescale 1ns / 1ps

// Input channel: one magnetometer sample and a command.
interface cmphd_req_if;
   import cmphd_pkg::*;
   logic       valid;
   logic       ready;
   cmd_type    cmd;
   sample_type mag_x;
   sample_type mag_y;
   sample_type mag_z;
   modport source (output valid, cmd, mag_x, mag_y, mag_z, input ready);
   modport sink   (input valid, cmd, mag_x, mag_y, mag_z, output ready);
endinterface

// Result channel: heading and the current offsets.
interface cmphd_rsp_if;
   import cmphd_pkg::*;
   logic        valid;
   logic        ready;
   heading_type heading;
   sample_type  offset_x;
   sample_type  offset_y;
   sample_type  offset_z;
   modport source (output valid, heading, offset_x, offset_y, offset_z, input ready);
   modport sink   (input valid, heading, offset_x, offset_y, offset_z, output ready);
endinterface

// Configuration write channel for the single control register.
interface cmphd_csr_if;
   logic valid;
   logic ready;
   logic invert_y;
   modport source (output valid, invert_y, input ready);
   modport sink   (input valid, invert_y, output ready);
endinterface

/* design/compass_heading_hard_iron_cal.sv */
`timescale 1ns / 1ps
// Hard-iron calibrated compass heading. Each item carries a command and one
// magnetometer sample (y is negated first when invert_y is set). Seed and widen
// commands track the per-axis minimum and maximum, the offsets command sets each
// offset to the truncated midpoint of its envelope, and the heading command
// removes the offsets and returns 360 minus atan2(y, x) in whole degrees,
// modulo 360. Every result item also reports the three offsets. The
// seed, widen and offsets commands are settled in the cycle that takes the item,
// and the block then passes through its hand-over state before it takes the next
// item. A heading runs through one CORDIC rotator that is reused once per step,
// and no new item is taken until the result is handed over; the exact-axis and
// zero-vector cases skip the rotator. The finished result sits in an output
// register, so a new item is taken while it waits to be collected, and only a
// second finished result waits for the first to leave.
module compass_heading_hard_iron_cal #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   cmphd_req_if.sink   req_bus,
   cmphd_rsp_if.source rsp_bus,
   cmphd_csr_if.sink   csr_bus
);
   import cmphd_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_ITER = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic              invert_y_ff, invert_y_in;
   sample_type        min_x_ff, min_x_in, max_x_ff, max_x_in;
   sample_type        min_y_ff, min_y_in, max_y_ff, max_y_in;
   sample_type        min_z_ff, min_z_in, max_z_ff, max_z_in;
   sample_type        off_x_ff, off_x_in, off_y_ff, off_y_in, off_z_ff, off_z_in;
   diff_type          dx_ff, dx_in, dy_ff, dy_in;
   xy_type            x_ff, x_in, y_ff, y_in;
   ang_type           ang_ff, ang_in;
   logic [STEP_W-1:0] step_ff, step_in;
   heading_type       result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   heading_type       rsp_heading_ff, rsp_heading_in;
   sample_type        rsp_off_x_ff, rsp_off_x_in;
   sample_type        rsp_off_y_ff, rsp_off_y_in;
   sample_type        rsp_off_z_ff, rsp_off_z_in;

   logic       req_take;
   logic       rsp_free;
   sample_type samp_y;
   xy_type     x_scaled, y_scaled, x_shift, y_shift;
   ang_type    turn_left;
   logic [9:0] whole_deg;

   // Rounds a 17-bit sum towards zero before halving it.
   function automatic sample_type midpoint(input sample_type hi, input sample_type lo);
      diff_type sum;
      diff_type adj;
      sum = diff_type'(hi) + diff_type'(lo);
      adj = sum + diff_type'({1'b0, sum[DIFF_W-1]});
      return sample_type'(adj >>> 1);
   endfunction

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.heading  = rsp_heading_ff;
   assign rsp_bus.offset_x = rsp_off_x_ff;
   assign rsp_bus.offset_y = rsp_off_y_ff;
   assign rsp_bus.offset_z = rsp_off_z_ff;

   // The y sample wraps on negation, as a 16-bit two's complement value would.
   assign samp_y = invert_y_ff ? -req_bus.mag_y : req_bus.mag_y;

   // Differences scaled by 256 and sign-extended for the CORDIC datapath.
   assign x_scaled = xy_type'($signed({dx_ff, 8'h00}));
   assign y_scaled = xy_type'($signed({dy_ff, 8'h00}));

   // The shared rotator's shifters: floor shifts by the current step.
   assign x_shift = x_ff >>> step_ff;
   assign y_shift = y_ff >>> step_ff;

   // The final angle stays within about 280 degrees either way, so the
   // whole-degree value lies in 80..640 and one subtraction wraps it.
   assign turn_left = FULL_TURN_Q16 - ang_ff;
   assign whole_deg = turn_left[FRAC_W+9:FRAC_W];

   always_comb begin
      state_in       = state_ff;
      invert_y_in    = invert_y_ff;
      min_x_in       = min_x_ff;
      max_x_in       = max_x_ff;
      min_y_in       = min_y_ff;
      max_y_in       = max_y_ff;
      min_z_in       = min_z_ff;
      max_z_in       = max_z_ff;
      off_x_in       = off_x_ff;
      off_y_in       = off_y_ff;
      off_z_in       = off_z_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      ang_in         = ang_ff;
      step_in        = step_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_heading_in = rsp_heading_ff;
      rsp_off_x_in   = rsp_off_x_ff;
      rsp_off_y_in   = rsp_off_y_ff;
      rsp_off_z_in   = rsp_off_z_ff;

      if (csr_bus.valid) begin
         invert_y_in = csr_bus.invert_y;
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               result_in = '0;
               state_in  = S_DONE;
               case (req_bus.cmd)
                  CMD_SEED: begin
                     min_x_in = req_bus.mag_x;
                     max_x_in = req_bus.mag_x;
                     min_y_in = samp_y;
                     max_y_in = samp_y;
                     min_z_in = req_bus.mag_z;
                     max_z_in = req_bus.mag_z;
                  end
                  CMD_WIDEN: begin
                     if (req_bus.mag_x > max_x_ff) max_x_in = req_bus.mag_x;
                     if (req_bus.mag_x < min_x_ff) min_x_in = req_bus.mag_x;
                     if (samp_y > max_y_ff) max_y_in = samp_y;
                     if (samp_y < min_y_ff) min_y_in = samp_y;
                     if (req_bus.mag_z > max_z_ff) max_z_in = req_bus.mag_z;
                     if (req_bus.mag_z < min_z_ff) min_z_in = req_bus.mag_z;
                  end
                  CMD_OFFSETS: begin
                     off_x_in = midpoint(max_x_ff, min_x_ff);
                     off_y_in = midpoint(max_y_ff, min_y_ff);
                     off_z_in = midpoint(max_z_ff, min_z_ff);
                  end
                  default: begin
                     dx_in    = diff_type'(req_bus.mag_x) - diff_type'(off_x_ff);
                     dy_in    = diff_type'(samp_y) - diff_type'(off_y_ff);
                     state_in = S_PREP;
                  end
               endcase
            end
         end
         S_PREP: begin
            // Exact axes and the zero vector are answered without the rotator.
            // Otherwise a vector in the left half-plane is turned by half a
            // turn so that the CORDIC only sees positive x.
            step_in = '0;
            if (dy_ff == '0) begin
               result_in = (dx_ff < 0) ? heading_type'(180) : '0;
               state_in  = S_DONE;
            end else if (dx_ff == '0) begin
               result_in = (dy_ff > 0) ? heading_type'(270) : heading_type'(90);
               state_in  = S_DONE;
            end else if (dx_ff < 0) begin
               x_in     = -x_scaled;
               y_in     = -y_scaled;
               ang_in   = (dy_ff >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
               state_in = S_ITER;
            end else begin
               x_in     = x_scaled;
               y_in     = y_scaled;
               ang_in   = '0;
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            // One vectoring step: rotate towards the x axis.
            if (y_ff > 0) begin
               x_in   = x_ff + y_shift;
               y_in   = y_ff - x_shift;
               ang_in = ang_ff + atan_q16(TAB_IDX_W'(step_ff));
            end else begin
               x_in   = x_ff - y_shift;
               y_in   = y_ff + x_shift;
               ang_in = ang_ff - atan_q16(TAB_IDX_W'(step_ff));
            end
            if (step_ff == LAST_STEP) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FIN: begin
            result_in = (whole_deg >= 10'd360) ? heading_type'(whole_deg - 10'd360)
                                               : heading_type'(whole_deg);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_heading_in = result_ff;
               rsp_off_x_in   = off_x_ff;
               rsp_off_y_in   = off_y_ff;
               rsp_off_z_in   = off_z_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and the calibration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         invert_y_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_x_ff     <= '0;
         max_x_ff     <= '0;
         min_y_ff     <= '0;
         max_y_ff     <= '0;
         min_z_ff     <= '0;
         max_z_ff     <= '0;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
         off_z_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         invert_y_ff  <= invert_y_in;
         rsp_valid_ff <= rsp_valid_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         min_z_ff     <= min_z_in;
         max_z_ff     <= max_z_in;
         off_x_ff     <= off_x_in;
         off_y_ff     <= off_y_in;
         off_z_ff     <= off_z_in;
         step_ff      <= step_in;
      end
   end

   // Datapath and output payload.
   always_ff @(posedge clock) begin
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      ang_ff         <= ang_in;
      result_ff      <= result_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_off_x_ff   <= rsp_off_x_in;
      rsp_off_y_ff   <= rsp_off_y_in;
      rsp_off_z_ff   <= rsp_off_z_in;
   end

   // A calibration command goes straight to the hand-over state.
   a_calib_direct: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_bus.cmd != CMD_HEADING) |=> (state_ff == S_DONE))
      else $error("calibration item did not finish in one cycle");

   // The rotator never runs past its last step.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER) |-> (step_ff <= LAST_STEP))
      else $error("CORDIC step count out of range");

   // A bearing handed out is always a whole degree below a full turn.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_heading_ff < heading_type'(360)))
      else $error("heading outside 0 to 359");

   // A new item is only taken while no heading is in flight.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER || state_ff == S_FIN) |-> !req_bus.ready)
      else $error("input taken during a heading computation");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import cmphd_pkg::*;

   // The CORDIC depth used by the block, and the same depth in the bench's own model.
   localparam int CORDIC_STEPS = 16;

   // The run stops here whatever happens. It lies well above the longest correct run,
   // in which every item meets the longest sender gap, a full heading and a receiver
   // stall.
   localparam int CYCLE_LIMIT = 600000;

   // Number of random items in each invert_y phase, and the number of phases.
   localparam int PHASE_ITEMS = 340;
   localparam int PHASES      = 5;

   // One input item, one result item, and one row of the directed table.
   typedef struct packed {
      cmd_type    cmd;
      sample_type x;
      sample_type y;
      sample_type z;
   } mag_item_type;

   typedef struct packed {
      heading_type heading;
      sample_type  ox;
      sample_type  oy;
      sample_type  oz;
   } bearing_type;

   typedef struct packed {
      logic         inv;
      mag_item_type item;
      logic         typed;
      bearing_type  want;
   } corner_row_type;

   logic clock;
   logic reset;

   cmphd_req_if req_bus ();
   cmphd_rsp_if rsp_bus ();
   cmphd_csr_if csr_bus ();

   compass_heading_hard_iron_cal #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // The bench's own picture of the block: the envelope per axis, the hard-iron
   // offsets and the orientation bit. Index 0 is x, 1 is y and 2 is z.
   int   env_lo [3];
   int   env_hi [3];
   int   hard_iron [3];
   logic invert_now;

   // atan(2^-i) in degrees with 16 fraction bits, rounded, as in the block's table.
   longint arc_step_q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   // Results that the block owes us, oldest first.
   bearing_type    due_bearings [$];
   corner_row_type corner_rows [$];

   int cycle_count;
   int mismatches;
   int items_sent;
   int headings_sent;
   int results_seen;
   int invert_writes;
   int burst_left;

   // Heading from the offset-corrected differences. The exact axes and the null
   // vector are settled directly; everything else goes through a vectoring CORDIC
   // on the differences scaled by 256, with floor shifts and a 180 degree
   // pre-rotation for the left half-plane.
   function automatic heading_type bearing_of(input longint dx, input longint dy);
      longint vx;
      longint vy;
      longint acc;
      longint step_x;
      longint step_y;
      longint turn;
      if (dx == 0 && dy == 0) return '0;
      if (dy == 0) return (dx > 0) ? 9'd0 : 9'd180;
      if (dx == 0) return (dy > 0) ? 9'd270 : 9'd90;
      vx  = dx * 256;
      vy  = dy * 256;
      acc = 0;
      if (vx < 0) begin
         acc = (vy >= 0) ? 180 * 65536 : -180 * 65536;
         vx  = -vx;
         vy  = -vy;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         step_x = vy >>> i;
         step_y = vx >>> i;
         if (vy > 0) begin
            vx  += step_x;
            vy  -= step_y;
            acc += arc_step_q16[i];
         end else begin
            vx  -= step_x;
            vy  += step_y;
            acc -= arc_step_q16[i];
         end
      end
      turn = ((360 * 65536 - acc) >>> 16) % 360;
      if (turn < 0) turn += 360;
      return heading_type'(turn);
   endfunction

   // Applies one accepted item to the bench's state and gives the result the block
   // should return for it. The offsets reported are those after the item.
   function automatic bearing_type compass_step(input mag_item_type it);
      int          axis_val [3];
      bearing_type r;
      axis_val[0] = it.x;
      axis_val[1] = it.y;
      axis_val[2] = it.z;
      // Negation wraps in 16 bits, so the most negative sample stays as it is.
      if (invert_now) axis_val[1] = sample_type'(-axis_val[1]);
      r.heading = '0;
      case (it.cmd)
         CMD_SEED: begin
            for (int a = 0; a < 3; a++) begin
               env_lo[a] = axis_val[a];
               env_hi[a] = axis_val[a];
            end
         end
         CMD_WIDEN: begin
            for (int a = 0; a < 3; a++) begin
               if (axis_val[a] > env_hi[a]) env_hi[a] = axis_val[a];
               if (axis_val[a] < env_lo[a]) env_lo[a] = axis_val[a];
            end
         end
         CMD_OFFSETS: begin
            // Integer division truncates towards zero, as the block does.
            for (int a = 0; a < 3; a++) hard_iron[a] = (env_hi[a] + env_lo[a]) / 2;
         end
         default: begin
            r.heading = bearing_of(longint'(axis_val[0]) - hard_iron[0],
                                   longint'(axis_val[1]) - hard_iron[1]);
         end
      endcase
      r.ox = sample_type'(hard_iron[0]);
      r.oy = sample_type'(hard_iron[1]);
      r.oz = sample_type'(hard_iron[2]);
      return r;
   endfunction

   // A random sample for one axis. Corners and small values turn up often, and for
   // x and y a good share lands on or near the current offset, so that the exact
   // axes and the null vector are hit once the offsets are no longer zero.
   function automatic sample_type pick_sample(input int axis);
      int v;
      case ($urandom_range(0, 9))
         0, 1: begin
            case ($urandom_range(0, 3))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = 0;
               default: v = -1;
            endcase
         end
         2, 3: v = int'($urandom_range(0, 40)) - 20;
         4, 5, 6: begin
            if (axis < 2) begin
               v = hard_iron[axis];
               if ($urandom_range(0, 2) != 0) v += int'($urandom_range(0, 600)) - 300;
               if (axis == 1 && invert_now) v = -v;
            end else begin
               v = int'($urandom_range(0, 65535));
            end
         end
         default: v = int'($urandom_range(0, 65535));
      endcase
      return sample_type'(v);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic add_row(input logic inv, input cmd_type cmd, input sample_type x,
                          input sample_type y, input sample_type z, input logic typed,
                          input heading_type h, input sample_type ox,
                          input sample_type oy, input sample_type oz);
      corner_row_type row;
      row.inv   = inv;
      row.item  = '{cmd, x, y, z};
      row.typed = typed;
      row.want  = '{h, ox, oy, oz};
      corner_rows.push_back(row);
   endtask

   // Offers one item and waits for the block to take it. The expectation is
   // queued at the edge that accepts the item. The sender works in bursts: valid
   // stays high from item to item within a burst, and a burst ends with a gap with
   // valid low, so valid is never lowered and raised in the same step.
   task automatic send_item(input mag_item_type it, input logic typed,
                            input bearing_type want);
      bearing_type guess;
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= it.cmd;
      req_bus.mag_x <= it.x;
      req_bus.mag_y <= it.y;
      req_bus.mag_z <= it.z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      guess = compass_step(it);
      due_bearings.push_back(typed ? want : guess);
      items_sent++;
      if (it.cmd == CMD_HEADING) headings_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 25 : 3)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end
   endtask

   task automatic send_random(input cmd_type cmd);
      mag_item_type it;
      it.cmd = cmd;
      it.x   = pick_sample(0);
      it.y   = pick_sample(1);
      it.z   = pick_sample(2);
      send_item(it, 1'b0, '0);
   endtask

   // Stops offering items and waits until every owed result has been collected.
   // Each item gives exactly one result, so an empty queue means the block is idle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (due_bearings.size() != 0) @(posedge clock);
   endtask

   task automatic set_invert(input logic v);
      csr_bus.valid    <= 1'b1;
      csr_bus.invert_y <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      invert_now = v;
      invert_writes++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run is cut off if it goes on far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[compass_heading_hard_iron_cal] ERROR");
         $finish;
      end
   end

   // The receiver changes its behaviour every so often: always ready, a coin toss
   // per cycle, ready one cycle in four, or ready only one cycle in nine.
   initial begin : receiver_stalls
      int mode;
      int left;
      rsp_bus.ready <= 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 120);
         end
         left--;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= (left % 4 == 0);
            default: rsp_bus.ready <= (left % 9 == 0);
         endcase
      end
   end

   // Every accepted result is compared, field by field, with the oldest expectation.
   always @(posedge clock) begin : check_results
      bearing_type owed;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (due_bearings.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      results_seen));
         end else begin
            owed = due_bearings.pop_front();
            if (rsp_bus.heading !== owed.heading)
               report_mismatch($sformatf("result %0d heading %0d, predicted %0d",
                                         results_seen, rsp_bus.heading, owed.heading));
            if (rsp_bus.offset_x !== owed.ox)
               report_mismatch($sformatf("result %0d offset_x %0d, predicted %0d",
                                         results_seen, rsp_bus.offset_x, owed.ox));
            if (rsp_bus.offset_y !== owed.oy)
               report_mismatch($sformatf("result %0d offset_y %0d, predicted %0d",
                                         results_seen, rsp_bus.offset_y, owed.oy));
            if (rsp_bus.offset_z !== owed.oz)
               report_mismatch($sformatf("result %0d offset_z %0d, predicted %0d",
                                         results_seen, rsp_bus.offset_z, owed.oz));
         end
      end
   end

   initial begin : stimulus
      int phase_start;

      // Every input of the block is known from the first instant.
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_SEED;
      req_bus.mag_x    <= '0;
      req_bus.mag_y    <= '0;
      req_bus.mag_z    <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.invert_y <= 1'b0;

      cycle_count   = 0;
      mismatches    = 0;
      items_sent    = 0;
      headings_sent = 0;
      results_seen  = 0;
      invert_writes = 0;
      burst_left    = 0;
      invert_now    = 1'b0;
      for (int a = 0; a < 3; a++) begin
         env_lo[a]    = 0;
         env_hi[a]    = 0;
         hard_iron[a] = 0;
      end

      // Directed corners. Rows marked typed carry a result that can be read off
      // by hand; the others are left to the model above.
      // Straight after reset the offsets are zero: the null vector and the four
      // exact axes.
      add_row(1'b0, CMD_HEADING, 0, 0, 0, 1'b1, 0, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, 5, 0, -32768, 1'b1, 0, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, -5, 0, 32767, 1'b1, 180, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, 0, 7, 0, 1'b1, 270, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, 0, -7, 0, 1'b1, 90, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, 300, -400, 0, 1'b0, 0, 0, 0, 0);
      // Widening and offsets without any seed work from the all-zero envelope.
      add_row(1'b0, CMD_WIDEN, 32767, -32768, 100, 1'b1, 0, 0, 0, 0);
      add_row(1'b0, CMD_OFFSETS, 0, 0, 0, 1'b1, 0, 16383, -16384, 50);
      // The widest differences that the offsets allow.
      add_row(1'b0, CMD_HEADING, -32768, 32767, 0, 1'b0, 0, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, 32767, -32768, 0, 1'b0, 0, 0, 0, 0);
      // A full-scale envelope: the sum of -1 truncates to an offset of zero.
      add_row(1'b0, CMD_SEED, -32768, 32767, -32768, 1'b1, 0, 16383, -16384, 50);
      add_row(1'b0, CMD_WIDEN, 32767, -32768, 32767, 1'b1, 0, 16383, -16384, 50);
      add_row(1'b0, CMD_OFFSETS, 0, 0, 0, 1'b1, 0, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, 32767, 32767, 0, 1'b0, 0, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, -32768, -32768, 0, 1'b0, 0, 0, 0, 0);
      add_row(1'b0, CMD_HEADING, 1, -1, 0, 1'b0, 0, 0, 0, 0);
      // Odd negative sums round towards zero.
      add_row(1'b0, CMD_SEED, -3, 4, -1, 1'b1, 0, 0, 0, 0);
      add_row(1'b0, CMD_WIDEN, -2, 5, 0, 1'b1, 0, 0, 0, 0);
      add_row(1'b0, CMD_OFFSETS, 9, 9, 9, 1'b1, 0, -2, 4, 0);
      // With y inverted, the most negative sample negates to itself.
      add_row(1'b1, CMD_SEED, 0, -32768, 0, 1'b1, 0, -2, 4, 0);
      add_row(1'b1, CMD_OFFSETS, 0, 0, 0, 1'b1, 0, 0, -32768, 0);
      add_row(1'b1, CMD_HEADING, 0, -32768, 0, 1'b1, 0, 0, -32768, 0);
      add_row(1'b1, CMD_HEADING, 0, 100, 0, 1'b1, 270, 0, -32768, 0);
      add_row(1'b1, CMD_HEADING, -20, -32768, 0, 1'b1, 180, 0, -32768, 0);
      add_row(1'b1, CMD_HEADING, 77, 300, 5, 1'b0, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The register is written once straight after reset, then whenever a row
      // asks for the other orientation, always with the block idle.
      set_invert(1'b0);
      foreach (corner_rows[i]) begin
         if (corner_rows[i].inv != invert_now) begin
            drain_results();
            set_invert(corner_rows[i].inv);
         end
         send_item(corner_rows[i].item, corner_rows[i].typed, corner_rows[i].want);
      end

      // Random phases, alternating the orientation. Most of the traffic is a proper
      // calibration (seed, a few widens, offsets) followed by a run of headings;
      // the rest is stray commands in any order.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         set_invert(phase % 2 == 1);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               send_random(CMD_SEED);
               repeat ($urandom_range(1, 8)) send_random(CMD_WIDEN);
               send_random(CMD_OFFSETS);
               repeat ($urandom_range(3, 15)) send_random(CMD_HEADING);
            end else begin
               repeat ($urandom_range(1, 6))
                  send_random(cmd_type'($urandom_range(CMD_SEED, CMD_HEADING)));
            end
         end
      end

      // Wait for the last results, then a little longer in case anything stray
      // follows them.
      drain_results();
      repeat (2 * CORDIC_STEPS + 8) @(posedge clock);

      $display("Covered %0d items, %0d of them heading requests, and %0d results.",
               items_sent, headings_sent, results_seen);
      $display("invert_y was written %0d times across directed corners and random phases.",
               invert_writes);
      if (mismatches == 0) begin
         $display("[compass_heading_hard_iron_cal] OK");
      end else begin
         $display("[compass_heading_hard_iron_cal] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
design/cmphd_pkg.sv
design/cmphd_if.sv
design/compass_heading_hard_iron_cal.sv
bench/tb_top.sv
